// File: rtl/rtq_pkg.sv
// Shared types, codes and constants of the release time queue.
package rtq_pkg;

  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int TASK_ID_BITS_DEF = 8;
  localparam int HALF_BITS        = 32;
  localparam int TIME_BITS        = 2 * HALF_BITS;
  localparam int STATUS_BITS      = 3;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [HALF_BITS-1:0] half_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_QUEUED = 3'd0,
    ST_MISSED = 3'd1,
    ST_FULL   = 3'd2,
    ST_POPPED = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

  localparam logic OP_DELAY = 1'b0;
  localparam logic OP_POP   = 1'b1;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic  ins;
    logic  pop;
    time_t new_release;
  } cell_ctrl_t;

endpackage

// File: rtl/rtq_if.sv
// Valid/ready channel interfaces for request and result words.
interface rtq_in_if #(
  parameter int TASK_ID_BITS = rtq_pkg::TASK_ID_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [TASK_ID_BITS-1:0]       task_id;
  logic [rtq_pkg::HALF_BITS-1:0] release_high;
  logic [rtq_pkg::HALF_BITS-1:0] release_low;
  logic [rtq_pkg::TIME_BITS-1:0] current_time;

  modport source (output valid, operation, task_id, release_high, release_low,
                  current_time, input ready);
  modport sink   (input valid, operation, task_id, release_high, release_low,
                  current_time, output ready);
endinterface

interface rtq_out_if #(
  parameter int TASK_ID_BITS = rtq_pkg::TASK_ID_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic [rtq_pkg::STATUS_BITS-1:0] status;
  logic [TASK_ID_BITS-1:0]         removed_task;
  logic                            head_valid;
  logic [TASK_ID_BITS-1:0]         head_task;
  logic [rtq_pkg::TIME_BITS-1:0]   head_release;
  logic                            timer_updated;
  logic [rtq_pkg::TIME_BITS-1:0]   timer_expiry;

  modport source (output valid, status, removed_task, head_valid, head_task,
                  head_release, timer_updated, timer_expiry, input ready);
  modport sink   (input valid, status, removed_task, head_valid, head_task,
                  head_release, timer_updated, timer_expiry, output ready);
endinterface

// File: rtl/rtq_cell.sv
// One slot of the sorted queue row: holds a release time and a task id.
module rtq_cell #(
  parameter int TASK_ID_BITS = rtq_pkg::TASK_ID_BITS_DEF,
  parameter int CNT_BITS     = 5,
  parameter int IDX          = 0
) (
  input  logic                    clk,
  input  rtq_pkg::cell_ctrl_t     ctrl,
  input  logic [TASK_ID_BITS-1:0] new_tid,
  input  logic [CNT_BITS-1:0]     count,
  input  rtq_pkg::time_t          left_release,
  input  logic [TASK_ID_BITS-1:0] left_tid,
  input  logic                    left_gt,
  input  rtq_pkg::time_t          right_release,
  input  logic [TASK_ID_BITS-1:0] right_tid,
  output rtq_pkg::time_t          rel_q,
  output logic [TASK_ID_BITS-1:0] tid_q,
  output logic                    gt
);
  import rtq_pkg::*;

  logic occupied;
  logic here;

  assign occupied = count > CNT_BITS'(IDX);
  // The new word goes before this slot; ties stay behind it.
  assign gt   = occupied && (ctrl.new_release < rel_q);
  assign here = gt || !occupied;

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      rel_q <= right_release;
      tid_q <= right_tid;
    end else if (ctrl.ins) begin
      if (left_gt) begin
        rel_q <= left_release;
        tid_q <= left_tid;
      end else if (here) begin
        rel_q <= ctrl.new_release;
        tid_q <= new_tid;
      end
    end
  end

endmodule

// File: rtl/release_time_queue_core.sv
// Top level of the release time queue: control, timer and the row of cells.
//
//   channel | direction | handshake          | word
//   req     | in        | req.valid/ready    | operation, task, release, now
//   rsp     | out       | rsp.valid/ready    | status, head, timer expiry
//   cfg     | in        | cfg_we             | timer margin (32 bits)
//
// Each request passes through four steps: accept, check, the shift of the
// cell row, and the timer compare that loads the result register.
// A new request is taken while the previous result still waits in rsp.
// A stalled rsp holds the block in its timer step until the result moves.
// Reset (rst, synchronous) empties the queue and sets the expiry to all ones.
module release_time_queue_core #(
  parameter int QUEUE_DEPTH  = rtq_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_ID_BITS = rtq_pkg::TASK_ID_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [rtq_pkg::HALF_BITS-1:0] cfg_wdata,
  rtq_in_if.sink                   req,
  rtq_out_if.source                rsp
);
  import rtq_pkg::*;

  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_APPLY, S_TIMER} state_t;

  state_t                  state;
  logic                    op_r;
  logic [TASK_ID_BITS-1:0] tid_r;
  time_t                   rel_r;
  time_t                   now_r;
  status_t                 status_r;
  logic [TASK_ID_BITS-1:0] removed_r;
  logic [CNT_BITS-1:0]     count;
  time_t                   expiry;
  half_t                   margin;

  logic                    out_valid;
  status_t                 out_status;
  logic [TASK_ID_BITS-1:0] out_removed;
  logic                    out_head_valid;
  logic [TASK_ID_BITS-1:0] out_head_task;
  time_t                   out_head_release;
  logic                    out_updated;
  time_t                   out_expiry;

  time_t                   rel_arr [QUEUE_DEPTH];
  logic [TASK_ID_BITS-1:0] tid_arr [QUEUE_DEPTH];
  logic                    gt_arr  [QUEUE_DEPTH];
  cell_ctrl_t              ctrl;

  logic [TIME_BITS:0]      sum;
  time_t                   limit;
  logic                    lower;
  logic                    out_free;
  logic                    head_nonempty;

  assign req.ready = (state == S_IDLE);
  assign out_free  = !out_valid || rsp.ready;

  assign ctrl.ins         = (state == S_APPLY) && (status_r == ST_QUEUED);
  assign ctrl.pop         = (state == S_APPLY) && (status_r == ST_POPPED);
  assign ctrl.new_release = rel_r;

  assign sum   = {1'b0, expiry} + {{(TIME_BITS + 1 - HALF_BITS){1'b0}}, margin};
  assign limit = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
  assign lower = (status_r == ST_QUEUED) && (rel_arr[0] < limit);
  assign head_nonempty = (count != '0);

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      time_t                   l_rel, r_rel;
      logic [TASK_ID_BITS-1:0] l_tid, r_tid;
      logic                    l_gt;
      if (g == 0) begin : g_first
        assign l_rel = '0;
        assign l_tid = '0;
        assign l_gt  = 1'b0;
      end else begin : g_inner
        assign l_rel = rel_arr[g-1];
        assign l_tid = tid_arr[g-1];
        assign l_gt  = gt_arr[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_last
        assign r_rel = rel_arr[g];
        assign r_tid = tid_arr[g];
      end else begin : g_body
        assign r_rel = rel_arr[g+1];
        assign r_tid = tid_arr[g+1];
      end
      rtq_cell #(
        .TASK_ID_BITS (TASK_ID_BITS),
        .CNT_BITS     (CNT_BITS),
        .IDX          (g)
      ) u_cell (
        .clk           (clk),
        .ctrl          (ctrl),
        .new_tid       (tid_r),
        .count         (count),
        .left_release  (l_rel),
        .left_tid      (l_tid),
        .left_gt       (l_gt),
        .right_release (r_rel),
        .right_tid     (r_tid),
        .rel_q         (rel_arr[g]),
        .tid_q         (tid_arr[g]),
        .gt            (gt_arr[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      margin <= '0;
    end else if (cfg_we) begin
      margin <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      expiry    <= {TIME_BITS{1'b1}};
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (out_valid && rsp.ready) out_valid <= 1'b0;
          if (req.valid) begin
            op_r  <= req.operation;
            tid_r <= req.task_id;
            rel_r <= {req.release_high, req.release_low};
            now_r <= req.current_time;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (out_valid && rsp.ready) out_valid <= 1'b0;
          removed_r <= ((op_r == OP_POP) && (count != '0)) ? tid_arr[0] : '0;
          if (op_r == OP_DELAY) begin
            if (rel_r <= now_r) begin
              status_r <= ST_MISSED;
            end else if (count == CNT_BITS'(QUEUE_DEPTH)) begin
              status_r <= ST_FULL;
            end else begin
              status_r <= ST_QUEUED;
            end
          end else if (count == '0) begin
            status_r <= ST_EMPTY;
          end else begin
            status_r <= ST_POPPED;
          end
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (out_valid && rsp.ready) out_valid <= 1'b0;
          if (status_r == ST_QUEUED) count <= count + 1'b1;
          if (status_r == ST_POPPED) count <= count - 1'b1;
          state <= S_TIMER;
        end
        S_TIMER: begin
          // Wait here until the result register is free.
          if (out_free) begin
            if (lower) expiry <= rel_arr[0];
            out_valid        <= 1'b1;
            out_status       <= status_r;
            out_removed      <= removed_r;
            out_head_valid   <= head_nonempty;
            out_head_task    <= head_nonempty ? tid_arr[0] : '0;
            out_head_release <= head_nonempty ? rel_arr[0] : '0;
            out_updated      <= lower;
            out_expiry       <= lower ? rel_arr[0] : expiry;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.removed_task  = out_removed;
  assign rsp.head_valid    = out_head_valid;
  assign rsp.head_task     = out_head_task;
  assign rsp.head_release  = out_head_release;
  assign rsp.timer_updated = out_updated;
  assign rsp.timer_expiry  = out_expiry;

endmodule

// File: sim/rtq_scoreboard_pkg.sv
// Scoreboard for the release time queue: shadow queue, timer and the expected result words.
package rtq_scoreboard_pkg;
  import rtq_pkg::*;

  typedef struct packed {
    status_t          status;
    logic [7:0]       removed_task;
    logic             head_valid;
    logic [7:0]       head_task;
    time_t            head_release;
    logic             timer_updated;
    time_t            timer_expiry;
  } queue_result_t;

  class release_queue_shadow;
    bit [63:0]     slot_release [QUEUE_DEPTH_DEF];
    bit [7:0]      slot_task [QUEUE_DEPTH_DEF];
    int            held;
    bit [63:0]     expiry;
    bit [31:0]     margin;
    queue_result_t due_results [$];
    int unsigned   errors;

    function new();
      held = 0;
      expiry = '1;
      margin = '0;
      errors = 0;
    endfunction

    function void set_margin(bit [31:0] value);
      margin = value;
    endfunction

    function int awaited_count();
      return due_results.size();
    endfunction

    // Applies one accepted request word to the shadow state and queues its result.
    function void log_request(logic op, logic [7:0] tid, logic [31:0] rel_hi,
                              logic [31:0] rel_lo, logic [63:0] now);
      bit [63:0]     rel;
      bit [64:0]     sum;
      bit [63:0]     limit;
      int            pos;
      int            i;
      queue_result_t res;
      rel = {rel_hi, rel_lo};
      res = '0;
      res.status = ST_QUEUED;
      if (op == OP_DELAY) begin
        if (rel <= now) begin
          res.status = ST_MISSED;
        end else if (held >= QUEUE_DEPTH_DEF) begin
          res.status = ST_FULL;
        end else begin
          // Equal release times go behind the ones already held.
          pos = 0;
          while (pos < held && !(rel < slot_release[pos])) pos++;
          for (i = held; i > pos; i--) begin
            slot_release[i] = slot_release[i-1];
            slot_task[i] = slot_task[i-1];
          end
          slot_release[pos] = rel;
          slot_task[pos] = tid;
          held++;
          sum = {1'b0, expiry} + {33'd0, margin};
          limit = sum[64] ? '1 : sum[63:0];
          if (slot_release[0] < limit) begin
            expiry = slot_release[0];
            res.timer_updated = 1'b1;
          end
        end
      end else if (held == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.removed_task = slot_task[0];
        for (i = 1; i < held; i++) begin
          slot_release[i-1] = slot_release[i];
          slot_task[i-1] = slot_task[i];
        end
        held--;
        res.status = ST_POPPED;
      end
      if (held > 0) begin
        res.head_valid = 1'b1;
        res.head_task = slot_task[0];
        res.head_release = slot_release[0];
      end
      res.timer_expiry = expiry;
      due_results.push_back(res);
    endfunction

    function void check_field(string name, logic [63:0] want_v, logic [63:0] got_v,
                              longint unsigned stamp);
      if (got_v !== want_v) begin
        errors++;
        $display("%0d ns: %s mismatch: expected %h actual %h", stamp, name, want_v, got_v);
      end
    endfunction

    function void match_result(queue_result_t got, longint unsigned stamp);
      queue_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0d ns: unexpected result word: expected none actual status %0d",
                 stamp, got.status);
        return;
      end
      want = due_results.pop_front();
      check_field("status", want.status, got.status, stamp);
      check_field("removed_task", want.removed_task, got.removed_task, stamp);
      check_field("head_valid", want.head_valid, got.head_valid, stamp);
      check_field("head_task", want.head_task, got.head_task, stamp);
      check_field("head_release", want.head_release, got.head_release, stamp);
      check_field("timer_updated", want.timer_updated, got.timer_updated, stamp);
      check_field("timer_expiry", want.timer_expiry, got.timer_expiry, stamp);
    endfunction
  endclass

endpackage

// File: sim/tb_top.sv
// Top level testbench of the release time queue: clock, reset, stimulus and result monitor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rtq_pkg::*;
  import rtq_scoreboard_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  rtq_in_if  req_ch ();
  rtq_out_if rsp_ch ();

  release_time_queue_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  release_queue_shadow board;
  int                  requests_taken = 0;
  bit                  steady = 1'b0;
  time_t               sim_now;
  time_t               recent [$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Requests are logged before results so a word never races its own expectation.
  always @(posedge clk) begin
    queue_result_t got;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        board.log_request(req_ch.operation, req_ch.task_id, req_ch.release_high,
                          req_ch.release_low, req_ch.current_time);
        requests_taken++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status = status_t'(rsp_ch.status);
        got.removed_task = rsp_ch.removed_task;
        got.head_valid = rsp_ch.head_valid;
        got.head_task = rsp_ch.head_task;
        got.head_release = rsp_ch.head_release;
        got.timer_updated = rsp_ch.timer_updated;
        got.timer_expiry = rsp_ch.timer_expiry;
        board.match_result(got, longint'($time));
      end
    end
  end

  // Result side back-pressure: mostly ready, short stalls, now and then a long one.
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (steady) begin
        rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          rsp_ch.ready <= 1'b1;
        end else if (r < 95) begin
          stall_left = $urandom_range(0, 3);
          rsp_ch.ready <= 1'b0;
        end else begin
          stall_left = $urandom_range(10, 40);
          rsp_ch.ready <= 1'b0;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a falling edge; returns at a falling edge once the word was taken.
  task automatic send_item(logic op, logic [7:0] tid, time_t rel, time_t now_v);
    int target;
    int gap;
    target = requests_taken + 1;
    req_ch.operation <= op;
    req_ch.task_id <= tid;
    req_ch.release_high <= rel[63:32];
    req_ch.release_low <= rel[31:0];
    req_ch.current_time <= now_v;
    req_ch.valid <= 1'b1;
    do @(negedge clk); while (requests_taken != target);
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Waits until every expected word has arrived and the block has gone quiet.
  task automatic settle();
    if (req_ch.valid) req_ch.valid <= 1'b0;
    while (board.awaited_count() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_margin(logic [31:0] value);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_margin(value);
  endtask

  task automatic random_phase(int count);
    int         burst_left;
    int         fill_bias;
    int         pick;
    logic [7:0] tid;
    logic       op;
    time_t      rel;
    time_t      now_v;
    burst_left = 0;
    fill_bias = 80;
    repeat (count) begin
      // Pick insert-heavy or pop-heavy bursts at random so the queue swings between empty and full.
      if (burst_left == 0) begin
        fill_bias = $urandom_range(0, 1) ? 80 : 25;
        burst_left = $urandom_range(4, 40);
      end
      burst_left--;
      tid = 8'($urandom);
      if ($urandom_range(0, 99) < fill_bias) begin
        op = OP_DELAY;
        sim_now += $urandom_range(0, 1000);
        pick = $urandom_range(0, 99);
        now_v = sim_now;
        if (pick < 55) begin
          rel = sim_now + 1 + $urandom_range(0, 1 << 20);
        end else if (pick < 67 && recent.size() > 0) begin
          rel = recent[$urandom_range(0, recent.size() - 1)];
          now_v = (rel > 64'd100) ? rel - $urandom_range(1, 100) : 64'd0;
        end else if (pick < 77) begin
          rel = sim_now - $urandom_range(0, 500);
        end else if (pick < 87) begin
          rel = {$urandom, $urandom};
          now_v = {$urandom, $urandom};
        end else begin
          rel = sim_now + 1 + {24'd0, 8'($urandom), 32'($urandom)};
        end
        recent.push_back(rel);
        if (recent.size() > 8) void'(recent.pop_front());
      end else begin
        op = OP_POP;
        rel = {$urandom, $urandom};
        now_v = {$urandom, $urandom};
      end
      send_item(op, tid, rel, now_v);
    end
  endtask

  initial begin
    int          ph;
    int          i;
    logic [31:0] m;
    board = new();
    sim_now = 64'd1000;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.operation = OP_DELAY;
    req_ch.task_id = '0;
    req_ch.release_high = '0;
    req_ch.release_low = '0;
    req_ch.current_time = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_margin(32'hFFFF_FFFF);

    // Directed: empty pop, saturating margin, late requests, equal times, full queue.
    send_item(OP_POP, 8'h00, '0, '0);
    send_item(OP_DELAY, 8'hFF, 64'hFFFF_FFFF_FFFF_FFF0, 64'd0);
    send_item(OP_DELAY, 8'h00, '1, 64'hFFFF_FFFF_FFFF_FFFE);
    send_item(OP_DELAY, 8'h55, '1, '1);
    send_item(OP_DELAY, 8'hAA, 64'd5, 64'd5);
    send_item(OP_DELAY, 8'h01, 64'd100, 64'd0);
    send_item(OP_DELAY, 8'h02, 64'd100, 64'd0);
    send_item(OP_DELAY, 8'h03, 64'd100, 64'd0);
    for (i = 0; i < 11; i++) begin
      send_item(OP_DELAY, 8'(16 + i), 64'd50 + $urandom_range(0, 300), 64'd0);
    end
    send_item(OP_DELAY, 8'h77, 64'd1000, 64'd0);
    send_item(OP_DELAY, 8'h78, 64'd3, 64'd10);
    send_item(OP_POP, 8'hFF, '1, '1);
    send_item(OP_POP, 8'h00, '0, '1);

    for (ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: m = 32'd0;
        1: m = 32'hFFFF_FFFF;
        2: m = $urandom_range(0, 4096);
        4: m = 32'd1;
        default: m = $urandom;
      endcase
      write_margin(m);
      steady = (ph == 3);
      random_phase(300);
    end

    settle();
    if (board.errors == 0 && board.awaited_count() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
